/* rtl/sact_pkg.sv */
// Package: geometry constants, request/response/row types and address helpers for the tag store
`timescale 1ns / 1ps

package sact_pkg;

    // Cache geometry
    localparam int NUM_SETS    = 128;
    localparam int NUM_WAYS    = 8;
    localparam int TAG_BITS    = 13;
    localparam int OFFSET_BITS = 5;

    // Derived widths
    localparam int ADDR_W    = 25;
    localparam int SET_BITS  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_BITS  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int FILL_BITS = $clog2(NUM_WAYS + 1);
    localparam int TAG_LSB   = OFFSET_BITS + SET_BITS;
    localparam int WIDE_W    = ADDR_W + TAG_BITS;

    // Request commands
    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_FILL   = 2'd1,
        CMD_DIRTY  = 2'd2,
        CMD_INVAL  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd              command;
        logic [ADDR_W-1:0] phys_addr;
    } t_req;

    typedef struct packed {
        logic              hit;
        logic              victim_dirty;
        logic              upper_invalidate;
        logic [ADDR_W-1:0] upper_invalidate_addr;
    } t_rsp;

    // One way of a set
    typedef struct packed {
        logic                valid;
        logic                dirty;
        logic [TAG_BITS-1:0] tag;
    } t_way;

    // One set: all ways plus the replacement state
    typedef struct packed {
        t_way [NUM_WAYS-1:0]  ways;
        logic [FILL_BITS-1:0] fills;
        logic [WAY_BITS-1:0]  ptr;
    } t_row;

    localparam int ROW_W = $bits(t_row);

    // Set index, wrapped into range when NUM_SETS is not a power of two
    function automatic logic [SET_BITS-1:0] set_of(input logic [ADDR_W-1:0] addr);
        logic [SET_BITS-1:0] raw;
        raw = addr[OFFSET_BITS +: SET_BITS];
        if ({1'b0, raw} >= (SET_BITS + 1)'(NUM_SETS)) begin
            return raw - SET_BITS'(NUM_SETS);
        end
        return raw;
    endfunction

    // Tag field; bits past the address read as zero
    function automatic logic [TAG_BITS-1:0] tag_of(input logic [ADDR_W-1:0] addr);
        logic [WIDE_W-1:0] wide;
        wide = {{TAG_BITS{1'b0}}, addr};
        return wide[TAG_LSB +: TAG_BITS];
    endfunction

    // Line address rebuilt from tag and set, cut to the address width
    function automatic logic [ADDR_W-1:0] line_addr(input logic [TAG_BITS-1:0] tag,
                                                    input logic [SET_BITS-1:0] set);
        logic [WIDE_W-1:0] wide;
        wide = (WIDE_W'(tag) << TAG_LSB) | (WIDE_W'(set) << OFFSET_BITS);
        return wide[ADDR_W-1:0];
    endfunction

endpackage

/* rtl/sact_ram.sv */
// Generic single-clock RAM: one write port, one read port with registered read data
`timescale 1ns / 1ps

module sact_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sact_row_update.sv */
// Set row update: tag compare, way choice and the response for one request
`timescale 1ns / 1ps

module sact_row_update (
    input  sact_pkg::t_req i_req,
    input  sact_pkg::t_row i_row,
    output sact_pkg::t_row o_row,
    output sact_pkg::t_rsp o_rsp
);

    logic [sact_pkg::TAG_BITS-1:0] tag;
    logic [sact_pkg::SET_BITS-1:0] set;
    logic [sact_pkg::NUM_WAYS-1:0] match;
    logic [sact_pkg::NUM_WAYS-1:0] free;
    logic [sact_pkg::WAY_BITS-1:0] match_way;
    logic [sact_pkg::WAY_BITS-1:0] free_way;
    logic [sact_pkg::WAY_BITS-1:0] fill_way;
    logic                          hit;
    logic                          use_free;
    sact_pkg::t_way                victim;

    assign tag = sact_pkg::tag_of(i_req.phys_addr);
    assign set = sact_pkg::set_of(i_req.phys_addr);

    // Parallel compare and lowest-way priority encode
    always_comb begin
        match_way = '0;
        free_way  = '0;
        for (int w = sact_pkg::NUM_WAYS - 1; w >= 0; w--) begin
            match[w] = i_row.ways[w].valid && (i_row.ways[w].tag == tag);
            free[w]  = !i_row.ways[w].valid;
            if (match[w]) begin
                match_way = sact_pkg::WAY_BITS'(w);
            end
            if (free[w]) begin
                free_way = sact_pkg::WAY_BITS'(w);
            end
        end
    end

    assign hit      = |match;
    assign use_free = (i_row.fills < sact_pkg::FILL_BITS'(sact_pkg::NUM_WAYS)) && (|free);
    assign fill_way = use_free ? free_way : i_row.ptr;
    assign victim   = i_row.ways[i_row.ptr];

    // Command decode: new row contents and response
    always_comb begin
        o_row                       = i_row;
        o_rsp.hit                   = hit;
        o_rsp.victim_dirty          = 1'b0;
        o_rsp.upper_invalidate      = 1'b0;
        o_rsp.upper_invalidate_addr = '0;
        unique case (i_req.command)
            sact_pkg::CMD_LOOKUP: begin
            end
            sact_pkg::CMD_FILL: begin
                if (use_free) begin
                    o_row.fills = i_row.fills + 1'b1;
                end else begin
                    if (victim.valid) begin
                        o_rsp.victim_dirty          = victim.dirty;
                        o_rsp.upper_invalidate      = 1'b1;
                        o_rsp.upper_invalidate_addr = sact_pkg::line_addr(victim.tag, set);
                    end
                    o_row.ptr = (i_row.ptr == sact_pkg::WAY_BITS'(sact_pkg::NUM_WAYS - 1))
                                ? '0 : i_row.ptr + 1'b1;
                end
                o_row.ways[fill_way].valid = 1'b1;
                o_row.ways[fill_way].dirty = 1'b0;
                o_row.ways[fill_way].tag   = tag;
            end
            sact_pkg::CMD_DIRTY: begin
                if (hit) begin
                    o_row.ways[match_way].dirty = 1'b1;
                end
            end
            sact_pkg::CMD_INVAL: begin
                if (hit) begin
                    o_row.ways[match_way].valid = 1'b0;
                    o_rsp.upper_invalidate      = 1'b1;
                    o_rsp.upper_invalidate_addr = i_req.phys_addr;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/set_assoc_cache_tags_fifo_core.sv */
// Top level: set-associative tag store with FIFO replacement, one RAM row per set
//
//  channel   direction  handshake                       payload
//  request   in         start & !busy                   i_req  (command, phys_addr)
//  response  out        o_rsp_valid, one cycle strobe   o_rsp  (hit, victim_dirty,
//                                                               upper_invalidate, _addr)
//
// A transaction: the accept edge reads the set row from the RAM,
// the next cycle (busy high) updates and writes the row back, and the response
// strobes in the cycle after that, while the next request may already be accepted.
// Because of the RAM round trip of the set row, no new request is accepted while busy.
// Reset is synchronous; per-set valid flops make untouched rows read as empty,
// so no clearing pass is needed. The receiver cannot stall the response.
`timescale 1ns / 1ps

module set_assoc_cache_tags_fifo_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  sact_pkg::t_req i_req,
    output logic           o_rsp_valid,
    output sact_pkg::t_rsp o_rsp
);

    logic                          accept;
    logic                          r_busy;
    sact_pkg::t_req                r_req;
    logic [sact_pkg::SET_BITS-1:0] r_set;
    logic [sact_pkg::NUM_SETS-1:0] r_set_vld;
    logic                          r_rsp_valid;
    sact_pkg::t_rsp                r_rsp;
    logic [sact_pkg::ROW_W-1:0]    ram_rdata;
    sact_pkg::t_row                row_in;
    sact_pkg::t_row                row_out;
    sact_pkg::t_rsp                rsp;

    assign accept = start && !r_busy;

    // Set rows
    sact_ram #(
        .WIDTH (sact_pkg::ROW_W),
        .DEPTH (sact_pkg::NUM_SETS)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (r_busy),
        .i_waddr (r_set),
        .i_wdata (row_out),
        .i_re    (accept),
        .i_raddr (sact_pkg::set_of(i_req.phys_addr)),
        .o_rdata (ram_rdata)
    );

    // A never-written set reads as empty
    assign row_in = r_set_vld[r_set] ? sact_pkg::t_row'(ram_rdata) : '0;

    sact_row_update u_row_update (
        .i_req (r_req),
        .i_row (row_in),
        .o_row (row_out),
        .o_rsp (rsp)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_set_vld   <= '0;
        end else begin
            r_busy      <= accept;
            r_rsp_valid <= r_busy;
            if (r_busy) begin
                r_set_vld[r_set] <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
            r_set <= sact_pkg::set_of(i_req.phys_addr);
        end
        if (r_busy) begin
            r_rsp <= rsp;
        end
    end

    assign busy        = r_busy;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("accepted transaction did not raise busy");

    a_busy_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy)
        else $error("busy held longer than one cycle");

    a_busy_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> o_rsp_valid)
        else $error("no response after update cycle");

    a_victim_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.victim_dirty) |-> o_rsp.upper_invalidate)
        else $error("dirty victim without upper invalidate");

    a_inv_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.upper_invalidate) |-> (o_rsp.upper_invalidate_addr == '0))
        else $error("invalidate address set without invalidate");
`endif

endmodule

/* tb/set_assoc_cache_tags_fifo_checker.sv */
// Checker: predicts tag store responses from accepted requests and compares them in order
`timescale 1ns / 1ps

module set_assoc_cache_tags_fifo_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_busy,
    input  sact_pkg::t_req   i_req,
    input  logic             i_rsp_valid,
    input  sact_pkg::t_rsp   i_rsp,
    output int               o_fail_count,
    output int               o_pending
);
    import sact_pkg::*;

    localparam int MAX_REPORTS = 10;

    // Request kept next to its predicted response for mismatch reports
    typedef struct {
        t_req req;
        t_rsp rsp;
    } t_pending_rsp;

    // Predicted tag store contents
    logic                way_valid [NUM_SETS][NUM_WAYS];
    logic                way_dirty [NUM_SETS][NUM_WAYS];
    logic [TAG_BITS-1:0] way_tag   [NUM_SETS][NUM_WAYS];
    int                  set_fills [NUM_SETS];
    int                  set_ptr   [NUM_SETS];

    t_pending_rsp rsp_q [$];
    t_pending_rsp entry;
    int           fails;
    int           si;
    int           wi;

    // Apply one request to the predicted store and return the response it causes
    function automatic t_rsp tag_store_access(input t_req r);
        int                  set_idx;
        int                  hit_way;
        int                  slot;
        logic [TAG_BITS-1:0] tag;
        logic [ADDR_W-1:0]   victim;
        t_rsp                rsp;
        set_idx = int'(r.phys_addr[OFFSET_BITS +: SET_BITS]) % NUM_SETS;
        tag     = r.phys_addr[TAG_LSB +: TAG_BITS];
        rsp     = '0;
        hit_way = -1;
        // lowest valid way holding the tag, as seen before this request
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (hit_way < 0 && way_valid[set_idx][w] && way_tag[set_idx][w] == tag) begin
                hit_way = w;
            end
        end
        rsp.hit = (hit_way >= 0);
        case (r.command)
            CMD_FILL: begin
                slot = -1;
                // free way only while the set has not yet seen a full round of fills
                if (set_fills[set_idx] < NUM_WAYS) begin
                    for (int w = 0; w < NUM_WAYS; w++) begin
                        if (slot < 0 && !way_valid[set_idx][w]) begin
                            slot = w;
                        end
                    end
                end
                if (slot >= 0) begin
                    set_fills[set_idx]++;
                end else begin
                    slot = set_ptr[set_idx];
                    // an already invalid victim evicts nothing
                    if (way_valid[set_idx][slot]) begin
                        victim                          = '0;
                        victim[TAG_LSB +: TAG_BITS]     = way_tag[set_idx][slot];
                        victim[OFFSET_BITS +: SET_BITS] = SET_BITS'(set_idx);
                        rsp.victim_dirty                = way_dirty[set_idx][slot];
                        rsp.upper_invalidate            = 1'b1;
                        rsp.upper_invalidate_addr       = victim;
                    end
                    set_ptr[set_idx] = (slot + 1) % NUM_WAYS;
                end
                // filled line is always valid and clean
                way_valid[set_idx][slot] = 1'b1;
                way_dirty[set_idx][slot] = 1'b0;
                way_tag[set_idx][slot]   = tag;
            end
            CMD_DIRTY: begin
                if (hit_way >= 0) begin
                    way_dirty[set_idx][hit_way] = 1'b1;
                end
            end
            CMD_INVAL: begin
                // dirty bit stays; forwarded address is the request address as is
                if (hit_way >= 0) begin
                    way_valid[set_idx][hit_way] = 1'b0;
                    rsp.upper_invalidate        = 1'b1;
                    rsp.upper_invalidate_addr   = r.phys_addr;
                end
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    // Predict on request acceptance, compare on every response strobe
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (si = 0; si < NUM_SETS; si++) begin
                set_fills[si] = 0;
                set_ptr[si]   = 0;
                for (wi = 0; wi < NUM_WAYS; wi++) begin
                    way_valid[si][wi] = 1'b0;
                    way_dirty[si][wi] = 1'b0;
                    way_tag[si][wi]   = '0;
                end
            end
            rsp_q.delete();
            fails = 0;
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_start && !i_busy) begin
                entry.req = i_req;
                entry.rsp = tag_store_access(i_req);
                rsp_q.push_back(entry);
            end
            if (i_rsp_valid) begin
                if (rsp_q.size() == 0) begin
                    if (fails < MAX_REPORTS) begin
                        $display("%0t: response with no request outstanding", $realtime);
                        $display("    actual   hit=%0b vd=%0b inv=%0b addr=%h",
                                 i_rsp.hit, i_rsp.victim_dirty,
                                 i_rsp.upper_invalidate, i_rsp.upper_invalidate_addr);
                    end
                    fails++;
                end else begin
                    entry = rsp_q.pop_front();
                    if (i_rsp.hit !== entry.rsp.hit ||
                        i_rsp.victim_dirty !== entry.rsp.victim_dirty ||
                        i_rsp.upper_invalidate !== entry.rsp.upper_invalidate ||
                        i_rsp.upper_invalidate_addr !== entry.rsp.upper_invalidate_addr) begin
                        if (fails < MAX_REPORTS) begin
                            $display("%0t: mismatch for %s addr=%h", $realtime,
                                     entry.req.command.name(), entry.req.phys_addr);
                            $display("    expected hit=%0b vd=%0b inv=%0b addr=%h",
                                     entry.rsp.hit, entry.rsp.victim_dirty,
                                     entry.rsp.upper_invalidate,
                                     entry.rsp.upper_invalidate_addr);
                            $display("    actual   hit=%0b vd=%0b inv=%0b addr=%h",
                                     i_rsp.hit, i_rsp.victim_dirty,
                                     i_rsp.upper_invalidate, i_rsp.upper_invalidate_addr);
                        end
                        fails++;
                    end
                end
            end
            o_fail_count <= fails;
            o_pending    <= rsp_q.size();
        end
    end

endmodule

/* tb/tb_set_assoc_cache_tags_fifo_core.sv */
// Testbench top: request stimulus, watchdog and verdict for the FIFO-replacement tag store
`timescale 1ns / 1ps

module tb_set_assoc_cache_tags_fifo_core;
    import sact_pkg::*;

    localparam int RANDOM_ITEMS   = 1500;
    localparam int NUM_HOT_SETS   = 6;
    localparam int NUM_HOT_TAGS   = 12;
    // far beyond the longest sender gap plus the turnaround of one transaction
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic o_rsp_valid;
    t_req i_req;
    t_rsp o_rsp;

    int fail_count;
    int pending_count;
    int stall_cycles;
    int idle_pct;

    // small pools of sets and tags so fills collide and lookups hit
    logic [SET_BITS-1:0] hot_sets [NUM_HOT_SETS];
    logic [TAG_BITS-1:0] hot_tags [NUM_HOT_TAGS];

    set_assoc_cache_tags_fifo_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

    set_assoc_cache_tags_fifo_checker u_tag_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_req        (i_req),
        .i_rsp_valid  (o_rsp_valid),
        .i_rsp        (o_rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((start && !busy) || o_rsp_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Address of a line: tag, set index and byte offset
    function automatic logic [ADDR_W-1:0] line_in(input logic [TAG_BITS-1:0] tag,
                                                  input logic [SET_BITS-1:0] set_idx,
                                                  input logic [OFFSET_BITS-1:0] offset);
        logic [ADDR_W-1:0] addr;
        addr                          = '0;
        addr[TAG_LSB +: TAG_BITS]     = tag;
        addr[OFFSET_BITS +: SET_BITS] = set_idx;
        addr[OFFSET_BITS-1:0]         = offset;
        return addr;
    endfunction

    // Drive one request, with random idle cycles first, and hold it until accepted
    task automatic issue(input t_cmd cmd, input logic [ADDR_W-1:0] addr);
        t_req req;
        req.command   = cmd;
        req.phys_addr = addr;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        @(posedge i_clk);
        while (busy !== 1'b0) begin
            @(posedge i_clk);
        end
    endtask

    // Mostly traffic on the hot lines, the rest fully random requests
    task automatic issue_random();
        logic [ADDR_W-1:0] addr;
        t_cmd              cmd;
        int                pick;
        if ($urandom_range(99) < 80) begin
            addr = line_in(hot_tags[$urandom_range(NUM_HOT_TAGS-1)],
                           hot_sets[$urandom_range(NUM_HOT_SETS-1)],
                           OFFSET_BITS'($urandom));
            pick = $urandom_range(99);
            if (pick < 30) begin
                cmd = CMD_FILL;
            end else if (pick < 55) begin
                cmd = CMD_LOOKUP;
            end else if (pick < 75) begin
                cmd = CMD_DIRTY;
            end else begin
                cmd = CMD_INVAL;
            end
        end else begin
            addr = ADDR_W'($urandom);
            cmd  = t_cmd'($urandom_range(3));
        end
        issue(cmd, addr);
    endtask

    // Stimulus and verdict
    initial begin
        start    <= 1'b0;
        i_req    <= '0;
        i_rst_n  <= 1'b0;
        idle_pct = 0;

        hot_sets[0] = '0;
        hot_sets[1] = SET_BITS'(NUM_SETS - 1);
        for (int i = 2; i < NUM_HOT_SETS; i++) begin
            hot_sets[i] = SET_BITS'($urandom_range(NUM_SETS - 1));
        end
        hot_tags[0] = '0;
        hot_tags[1] = '1;
        for (int i = 2; i < NUM_HOT_TAGS; i++) begin
            hot_tags[i] = TAG_BITS'($urandom);
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // set 0: miss, fill, hit on another offset, dirty, duplicate fill
        issue(CMD_LOOKUP, '0);
        issue(CMD_FILL,   line_in('0, '0, '0));
        issue(CMD_LOOKUP, line_in('0, '0, '1));
        issue(CMD_DIRTY,  line_in('0, '0, '0));
        issue(CMD_FILL,   line_in('0, '0, '0));
        // fill the set up, then evict the dirty way 0
        for (int t = 1; t <= 6; t++) begin
            issue(CMD_FILL, line_in(TAG_BITS'(t), '0, '0));
        end
        issue(CMD_FILL,   line_in(TAG_BITS'(7), '0, '0));
        // drop the duplicate copy in way 1, then replace that invalid way
        issue(CMD_INVAL,  line_in('0, '0, OFFSET_BITS'(3)));
        issue(CMD_FILL,   line_in(TAG_BITS'(8), '0, '0));
        issue(CMD_LOOKUP, line_in(TAG_BITS'(7), '0, '0));
        // all-ones address: last set, largest tag
        issue(CMD_FILL,   '1);
        issue(CMD_DIRTY,  '1);
        issue(CMD_LOOKUP, '1);
        issue(CMD_INVAL,  '1);
        issue(CMD_DIRTY,  '1);
        issue(CMD_INVAL,  '1);
        issue(CMD_FILL,   '1);
        issue(CMD_LOOKUP, '1);

        // random traffic: light sender gaps, heavy gaps, back to back
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 23 : (phase == 1) ? 54 : 0;
            repeat (RANDOM_ITEMS / 3) issue_random();
        end
        start <= 1'b0;

        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/sact_pkg.sv
rtl/sact_ram.sv
rtl/sact_row_update.sv
rtl/set_assoc_cache_tags_fifo_core.sv
tb/set_assoc_cache_tags_fifo_checker.sv
tb/tb_set_assoc_cache_tags_fifo_core.sv
